// ===== design/assert_macros.svh =====
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under async active-low reset
`define GMP_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gmp assertion failed");

// next-cycle implication under async active-low reset
`define GMP_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gmp assertion failed");

`endif

// ===== design/gmp_pkg.sv =====
// ----------------------------------------------------------------------------
// gmp_pkg
// Shared widths, datapath operations and control/status bundles for the
// minimal polynomial unit.
// ----------------------------------------------------------------------------
package gmp_pkg;

	localparam int MAX_DEGREE = 16;	// largest modulus degree handled
	localparam int RES_W  = 16;	// residue width
	localparam int POLY_W = 17;	// polynomial width, also matrix columns
	localparam int NROWS  = 16;	// matrix rows
	localparam int CNT_W  = 5;	// degree, orbit and column counters
	localparam int T_W    = 6;	// running multiple of the orbit length

	localparam logic [POLY_W-1:0] MOD_RESET = 17'd19;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ_MUL,
		OP_SQ_TAKE,
		OP_FILL_INIT,
		OP_FILL_COL,
		OP_PW_TAKE,
		OP_ELIM,
		OP_KERNEL,
		OP_CHAR_INIT,
		OP_CP_MUL,
		OP_CP_TAKE,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic deg_bad;
		logic mul_done;
		logic sq_match;
		logic k_last;
		logic col_last;
		logic kernel_ok;
		logic cp_more;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== design/gmp_mul.sv =====
// ----------------------------------------------------------------------------
// gmp_mul
// Bit-serial GF(2) multiplier, one multiplier bit per cycle, msb first.
// Modular mode reduces by the modulus each step, plain mode truncates.
// ----------------------------------------------------------------------------
module gmp_mul import gmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              plain,
	input  logic [POLY_W-1:0] x,
	input  logic [POLY_W-1:0] y,
	input  logic [POLY_W-1:0] m,
	input  logic [CNT_W-1:0]  n,
	output logic              done,
	output logic [POLY_W-1:0] acc
);

	logic              busy_q;
	logic              done_q;
	logic              plain_q;
	logic [CNT_W-1:0]  idx_q;
	logic [POLY_W-1:0] x_q;
	logic [POLY_W-1:0] y_q;
	logic [POLY_W-1:0] acc_q;
	logic [POLY_W-1:0] shifted;
	logic [POLY_W-1:0] acc_nxt;

	always_comb begin
		shifted = {acc_q[POLY_W-2:0], 1'b0};
		if (!plain_q && shifted[n]) begin
			shifted = shifted ^ m;
		end
		acc_nxt = shifted ^ (y_q[idx_q] ? x_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && idx_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q     <= x;
			y_q     <= y;
			plain_q <= plain;
			acc_q   <= '0;
			idx_q   <= plain ? CNT_W'(POLY_W - 1) : n - 1'b1;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			idx_q <= idx_q - 1'b1;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

// ===== design/gmp_dp.sv =====
// ----------------------------------------------------------------------------
// gmp_dp
// Datapath: modulus register, orbit search, power matrix, gf(2) row
// reduction, kernel extraction, characteristic power and result register.
// ----------------------------------------------------------------------------
module gmp_dp import gmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic              cfg_we,
	input  logic [POLY_W-1:0] cfg_data,
	input  logic [RES_W-1:0]  element,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [POLY_W-1:0] min_poly,
	output logic [POLY_W-1:0] char_poly,
	output logic [CNT_W-1:0]  orbit_length,
	output logic              failed
);

	localparam logic [CNT_W:0] MaxDeg = (CNT_W+1)'(MAX_DEGREE);

	logic [POLY_W-1:0] modulus_q;
	logic [POLY_W-1:0] m_q;
	logic [CNT_W-1:0]  n_q;
	logic [RES_W-1:0]  a_q;
	logic [RES_W-1:0]  sq_q;
	logic [RES_W-1:0]  pw_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  l_q;
	logic [CNT_W-1:0]  rank_q;
	logic [T_W-1:0]    t_q;
	logic              fail_q;
	logic [POLY_W-1:0] mp_q;
	logic [POLY_W-1:0] cp_q;
	logic [POLY_W-1:0] rows_q [NROWS];
	logic [CNT_W-1:0]  pivcol_q [NROWS];
	logic [NROWS-1:0]  used_q;
	logic [POLY_W-1:0] pivmask_q;
	logic              out_valid_q;
	logic [POLY_W-1:0] min_q;
	logic [POLY_W-1:0] char_q;
	logic [CNT_W-1:0]  len_q;
	logic              failed_q;

	// degree of the live modulus and element mask
	logic [CNT_W-1:0]  deg;
	logic [RES_W-1:0]  nmask;
	logic              deg_bad;

	always_comb begin
		deg = '0;
		for (int i = 0; i < POLY_W; i++) begin
			if (modulus_q[i]) begin
				deg = CNT_W'(i);
			end
		end
		for (int i = 0; i < RES_W; i++) begin
			nmask[i] = CNT_W'(i) < deg;
		end
		deg_bad = (modulus_q[POLY_W-1:1] == '0) || ({1'b0, deg} > MaxDeg);
	end

	// shared multiplier
	logic              mul_start;
	logic              mul_plain;
	logic [POLY_W-1:0] mul_x;
	logic [POLY_W-1:0] mul_y;
	logic              mul_done;
	logic [POLY_W-1:0] mul_acc;

	always_comb begin
		mul_start = 1'b0;
		mul_plain = 1'b0;
		mul_x     = {1'b0, sq_q};
		mul_y     = {1'b0, sq_q};
		case (cmd.op)
			OP_SQ_MUL: begin
				mul_start = 1'b1;
			end
			OP_FILL_COL: begin
				mul_start = (j_q != l_q);
				mul_x     = {1'b0, pw_q};
				mul_y     = {1'b0, a_q};
			end
			OP_CP_MUL: begin
				mul_start = 1'b1;
				mul_plain = 1'b1;
				mul_x     = cp_q;
				mul_y     = mp_q;
			end
			default: begin
			end
		endcase
	end

	gmp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.plain  (mul_plain),
		.x      (mul_x),
		.y      (mul_y),
		.m      (m_q),
		.n      (n_q),
		.done   (mul_done),
		.acc    (mul_acc)
	);

	// pivot search for column j among rows not yet used
	logic [NROWS-1:0]  cand;
	logic [NROWS-1:0]  piv_oh;
	logic [POLY_W-1:0] piv_row;

	always_comb begin
		for (int r = 0; r < NROWS; r++) begin
			cand[r] = !used_q[r] && rows_q[r][j_q];
		end
		piv_oh  = cand & (~cand + 1'b1);
		piv_row = '0;
		for (int r = 0; r < NROWS; r++) begin
			if (piv_oh[r]) begin
				piv_row = piv_row | rows_q[r];
			end
		end
	end

	// free column and kernel vector
	logic [CNT_W-1:0]  free_col;
	logic [POLY_W-1:0] kern;

	always_comb begin
		free_col = '0;
		for (int c = POLY_W - 1; c >= 0; c--) begin
			if (!pivmask_q[c]) begin
				free_col = CNT_W'(c);
			end
		end
		kern = '0;
		kern[free_col] = 1'b1;
		for (int r = 0; r < NROWS; r++) begin
			if (used_q[r] && rows_q[r][free_col]) begin
				kern[pivcol_q[r]] = 1'b1;
			end
		end
	end

	assign sts.deg_bad   = deg_bad;
	assign sts.mul_done  = mul_done;
	assign sts.sq_match  = (mul_acc == {1'b0, a_q});
	assign sts.k_last    = (k_q == n_q);
	assign sts.col_last  = (j_q == l_q);
	assign sts.kernel_ok = (rank_q == l_q);
	assign sts.cp_more   = (t_q <= {1'b0, n_q});
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= MOD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				modulus_q <= cfg_data;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				m_q    <= modulus_q;
				n_q    <= deg;
				a_q    <= element & nmask;
				sq_q   <= element & nmask;
				k_q    <= CNT_W'(1);
				l_q    <= '0;
				fail_q <= deg_bad;
			end
			OP_SQ_TAKE: begin
				sq_q <= mul_acc[RES_W-1:0];
				k_q  <= k_q + 1'b1;
				if (sts.sq_match) begin
					l_q <= k_q;
				end else if (k_q == n_q) begin
					fail_q <= 1'b1;
				end
			end
			OP_FILL_INIT: begin
				pw_q      <= RES_W'(1);
				j_q       <= '0;
				used_q    <= '0;
				rank_q    <= '0;
				pivmask_q <= '0;
				for (int r = 0; r < NROWS; r++) begin
					rows_q[r] <= '0;
				end
			end
			OP_FILL_COL: begin
				for (int r = 0; r < NROWS; r++) begin
					rows_q[r][j_q] <= pw_q[r];
				end
				if (j_q == l_q) begin
					j_q <= '0;
				end
			end
			OP_PW_TAKE: begin
				pw_q <= mul_acc[RES_W-1:0];
				j_q  <= j_q + 1'b1;
			end
			OP_ELIM: begin
				j_q <= j_q + 1'b1;
				if (cand != '0) begin
					pivmask_q[j_q] <= 1'b1;
					rank_q         <= rank_q + 1'b1;
					for (int r = 0; r < NROWS; r++) begin
						if (piv_oh[r]) begin
							used_q[r]   <= 1'b1;
							pivcol_q[r] <= j_q;
						end else if (rows_q[r][j_q]) begin
							rows_q[r] <= rows_q[r] ^ piv_row;
						end
					end
				end
			end
			OP_KERNEL: begin
				mp_q <= kern;
				if (rank_q != l_q) begin
					fail_q <= 1'b1;
				end
			end
			OP_CHAR_INIT: begin
				cp_q <= POLY_W'(1);
				t_q  <= {1'b0, l_q};
			end
			OP_CP_MUL: begin
				t_q <= t_q + {1'b0, l_q};
			end
			OP_CP_TAKE: begin
				cp_q <= mul_acc;
			end
			OP_OUT: begin
				min_q    <= fail_q ? '0 : mp_q;
				char_q   <= fail_q ? '0 : cp_q;
				len_q    <= l_q;
				failed_q <= fail_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign min_poly     = min_q;
	assign char_poly    = char_q;
	assign orbit_length = len_q;
	assign failed       = failed_q;

endmodule

// ===== design/gmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// gmp_ctrl
// Sequencer: orbit search, matrix fill, elimination, kernel, power, output.
// ----------------------------------------------------------------------------
module gmp_ctrl import gmp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_CHECK = 11'b00000000010,
		S_SQ    = 11'b00000000100,
		S_FINIT = 11'b00000001000,
		S_FCOL  = 11'b00000010000,
		S_FMUL  = 11'b00000100000,
		S_ELIM  = 11'b00001000000,
		S_KERN  = 11'b00010000000,
		S_CINIT = 11'b00100000000,
		S_CPOW  = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   cmul_q;	// a power step multiply is in flight

	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op    = OP_LOAD;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.deg_bad) begin
					state_nxt = S_DONE;
				end else begin
					cmd.op    = OP_SQ_MUL;
					state_nxt = S_SQ;
				end
			end
			S_SQ: begin
				if (sts.mul_done) begin
					cmd.op = OP_SQ_TAKE;
					if (sts.sq_match) begin
						state_nxt = S_FINIT;
					end else if (sts.k_last) begin
						state_nxt = S_DONE;
					end else begin
						state_nxt = S_CHECK;
					end
				end
			end
			S_FINIT: begin
				cmd.op    = OP_FILL_INIT;
				state_nxt = S_FCOL;
			end
			S_FCOL: begin
				cmd.op    = OP_FILL_COL;
				state_nxt = sts.col_last ? S_ELIM : S_FMUL;
			end
			S_FMUL: begin
				if (sts.mul_done) begin
					cmd.op    = OP_PW_TAKE;
					state_nxt = S_FCOL;
				end
			end
			S_ELIM: begin
				cmd.op = OP_ELIM;
				if (sts.col_last) begin
					state_nxt = S_KERN;
				end
			end
			S_KERN: begin
				cmd.op    = OP_KERNEL;
				state_nxt = sts.kernel_ok ? S_CINIT : S_DONE;
			end
			S_CINIT: begin
				cmd.op    = OP_CHAR_INIT;
				state_nxt = S_CPOW;
			end
			S_CPOW: begin
				if (cmul_q) begin
					if (sts.mul_done) begin
						cmd.op = OP_CP_TAKE;
					end
				end else if (sts.cp_more) begin
					cmd.op = OP_CP_MUL;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.op    = OP_OUT;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmul_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.op == OP_CP_MUL) begin
				cmul_q <= 1'b1;
			end else if (cmd.op == OP_CP_TAKE) begin
				cmul_q <= 1'b0;
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ===== design/gf2m_minimal_polynomial_unit.sv =====
// ----------------------------------------------------------------------------
// gf2m_minimal_polynomial_unit
// Minimal and characteristic polynomial of an element of GF(2^n).
//
// channel  direction  handshake             payload
// input    in         in_valid / in_stall   element
// output   out        out_valid / out_stall min_poly char_poly orbit_length failed
// config   in         cfg_valid / cfg_ready modulus_poly
//
// one item at a time; the bit-serial multiplier sets the pace of each orbit
// squaring, each matrix power and each power step; elimination handles one
// column per cycle.
// async reset loads the modulus x^4+x+1 and empties the result register.
// the result register frees the core, so the next element is taken while
// an earlier result is stalled.
// ----------------------------------------------------------------------------
module gf2m_minimal_polynomial_unit import gmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [RES_W-1:0]  element,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [POLY_W-1:0] min_poly,
	output logic [POLY_W-1:0] char_poly,
	output logic [CNT_W-1:0]  orbit_length,
	output logic              failed,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [POLY_W-1:0] modulus_poly
);

	`include "assert_macros.svh"

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	gmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	gmp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (modulus_poly),
		.element      (element),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.min_poly     (min_poly),
		.char_poly    (char_poly),
		.orbit_length (orbit_length),
		.failed       (failed)
	);

	`GMP_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall)
	`GMP_ASSERT_IMP(a_fail_zero, clk, arst_n, out_valid && failed, min_poly == '0 && char_poly == '0)
	`GMP_ASSERT_IMP(a_ok_has_orbit, clk, arst_n, out_valid && !failed, orbit_length != '0)

endmodule

// ===== sim/gf2m_minimal_polynomial_checker.sv =====
// ----------------------------------------------------------------------------
// gf2m_minimal_polynomial_checker
// Watches the element, result and modulus channels of the minimal polynomial
// unit, computes the expected minimal/characteristic polynomial of every
// accepted element and compares each accepted result in order.
// ----------------------------------------------------------------------------
module gf2m_minimal_polynomial_checker import gmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [RES_W-1:0]  element,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [POLY_W-1:0] min_poly,
	input  logic [POLY_W-1:0] char_poly,
	input  logic [CNT_W-1:0]  orbit_length,
	input  logic              failed,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [POLY_W-1:0] modulus_poly,
	output int                fail_count,
	output int                pending
);

	localparam int MAXD = MAX_DEGREE;

	typedef struct packed {
		logic [POLY_W-1:0] mp;
		logic [POLY_W-1:0] cp;
		logic [CNT_W-1:0]  orbit;
		logic              bad;
	} poly_result_t;

	logic [POLY_W-1:0] modulus_reg;
	poly_result_t      awaited_results[$];

	function automatic int degree_of(logic [63:0] p);
		int d;
		d = -1;
		for (int i = 0; i < 64; i++)
			if (p[i])
				d = i;
		return d;
	endfunction

	function automatic logic [63:0] field_mul(logic [63:0] x, logic [63:0] y,
			logic [63:0] m, int n);
		logic [63:0] prod;
		prod = 0;
		for (int i = 0; i < n; i++)
			if (y[i])
				prod ^= x << i;
		for (int i = 2 * n - 2; i >= n; i--)
			if (prod[i])
				prod ^= m << (i - n);
		return prod;
	endfunction

	function automatic poly_result_t minimal_poly_of(logic [RES_W-1:0] elem,
			logic [POLY_W-1:0] modulus);
		poly_result_t res;
		logic [63:0] m, a, sq, pw, nmask, mp, cp, prod, t;
		logic [63:0] rows[MAXD+1];
		int pivcol[MAXD+1];
		int n, l, cols, rank, sel, free_col, e;
		logic piv;
		res = '0;
		res.bad = 1'b1;
		m = 64'(modulus);
		n = degree_of(m);
		if (n < 1 || n > MAXD)
			return res;
		nmask = (64'd1 << n) - 1;
		a = 64'(elem) & nmask;
		l = 0;
		sq = a;
		for (int k = 1; k <= n; k++) begin
			sq = field_mul(sq, sq, m, n);
			if (sq == a) begin
				l = k;
				break;
			end
		end
		if (l == 0)
			return res;
		res.orbit = CNT_W'(l);
		cols = l + 1;
		for (int i = 0; i <= MAXD; i++)
			rows[i] = 0;
		pw = 64'd1 & nmask;
		if (n == 1)
			pw = field_mul(1, 1, m, n);
		for (int j = 0; j < cols; j++) begin
			for (int i = 0; i < n; i++)
				if (pw[i])
					rows[i][j] = 1'b1;
			pw = field_mul(pw, a, m, n);
		end
		rank = 0;
		for (int j = 0; j < cols && rank < n; j++) begin
			sel = -1;
			for (int r = rank; r < n; r++)
				if (rows[r][j] && sel < 0)
					sel = r;
			if (sel < 0)
				continue;
			t = rows[sel];
			rows[sel] = rows[rank];
			rows[rank] = t;
			for (int r = 0; r < n; r++)
				if (r != rank && rows[r][j])
					rows[r] ^= rows[rank];
			pivcol[rank] = j;
			rank++;
		end
		if (cols - rank != 1)
			return res;
		free_col = 0;
		for (int j = cols - 1; j >= 0; j--) begin
			piv = 1'b0;
			for (int r = 0; r < rank; r++)
				if (pivcol[r] == j)
					piv = 1'b1;
			if (!piv)
				free_col = j;
		end
		mp = 64'd1 << free_col;
		for (int r = 0; r < rank; r++)
			if (rows[r][free_col])
				mp[pivcol[r]] = 1'b1;
		e = n / l;
		cp = 1;
		for (int k = 0; k < e; k++) begin
			prod = 0;
			for (int i = 0; i < 33; i++)
				if (mp[i])
					prod ^= cp << i;
			cp = prod & 64'h1_FFFF_FFFF;
		end
		res.mp = POLY_W'(mp);
		res.cp = POLY_W'(cp);
		res.bad = 1'b0;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	assign pending = awaited_results.size();

	always @(posedge clk or negedge arst_n) begin
		poly_result_t want;
		if (!arst_n) begin
			modulus_reg <= MOD_RESET;
			awaited_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				modulus_reg <= modulus_poly;
			if (in_valid && !in_stall)
				awaited_results.push_back(minimal_poly_of(element, modulus_reg));
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$display("unexpected result transfer at %0t", $time);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (min_poly !== want.mp)
						report_mismatch("min_poly", 32'(min_poly), 32'(want.mp));
					if (char_poly !== want.cp)
						report_mismatch("char_poly", 32'(char_poly), 32'(want.cp));
					if (orbit_length !== want.orbit)
						report_mismatch("orbit_length", 32'(orbit_length),
							32'(want.orbit));
					if (failed !== want.bad)
						report_mismatch("failed", 32'(failed), 32'(want.bad));
				end
			end
		end
	end

endmodule

// ===== sim/gf2m_minimal_polynomial_unit_test.sv =====
// ----------------------------------------------------------------------------
// gf2m_minimal_polynomial_unit_test
// Drives elements through several modulus settings (irreducible, reducible,
// degenerate, extremes) with random gaps and stalls; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module gf2m_minimal_polynomial_unit_test import gmp_pkg::*; ();

	localparam longint CYCLE_LIMIT = 4_000_000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [RES_W-1:0]  element;
	logic              out_valid;
	logic              out_stall;
	logic [POLY_W-1:0] min_poly;
	logic [POLY_W-1:0] char_poly;
	logic [CNT_W-1:0]  orbit_length;
	logic              failed;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [POLY_W-1:0] modulus_poly;
	int                fail_count;
	int                pending;
	longint            cycle_count = 0;
	logic              hold_off;

	gf2m_minimal_polynomial_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .element(element),
		.out_valid(out_valid), .out_stall(out_stall),
		.min_poly(min_poly), .char_poly(char_poly),
		.orbit_length(orbit_length), .failed(failed),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .modulus_poly(modulus_poly)
	);

	gf2m_minimal_polynomial_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .element(element),
		.out_valid(out_valid), .out_stall(out_stall),
		.min_poly(min_poly), .char_poly(char_poly),
		.orbit_length(orbit_length), .failed(failed),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .modulus_poly(modulus_poly),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int gap_length();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 600);
		return $urandom_range(0, 3);
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (6000) @(posedge clk);
				out_stall <= 1'b0;
				wait (!hold_off);
			end
			n = $urandom_range(0, 2) == 0 ? gap_length() : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_element(logic [RES_W-1:0] value, logic quiet);
		int n;
		n = quiet ? 0 : gap_length();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		element <= value;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic write_modulus(logic [POLY_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (700) @(posedge clk);
		cfg_valid <= 1'b1;
		modulus_poly <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [POLY_W-1:0] modulus, int count);
		int n;
		write_modulus(modulus);
		n = 0;
		while ((1 << (n + 1)) <= modulus && n < 16)
			n++;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0 || n == 0)
				send_element(RES_W'($urandom), 1'b0);
			else
				send_element(RES_W'($urandom_range(0, (1 << n) - 1)), 1'b0);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		logic [RES_W-1:0] directed[$];
		directed = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
			16'h0006, 16'h000F, 16'h0010, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA};
		arst_n = 1'b0;
		in_valid = 1'b0;
		element = '0;
		cfg_valid = 1'b0;
		modulus_poly = '0;
		hold_off = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset modulus x^4+x+1, directed extremes
		foreach (directed[i])
			send_element(directed[i], 1'b0);
		// back-to-back offers while the receiver holds off
		hold_off <= 1'b1;
		for (int i = 0; i < 8; i++)
			send_element(RES_W'($urandom), 1'b1);
		in_valid <= 1'b0;
		hold_off <= 1'b0;
		// degenerate, small, reducible, maximum and largest-width moduli
		write_modulus(17'd0);
		send_element(16'h1234, 1'b0);
		write_modulus(17'd1);
		send_element(16'hFFFF, 1'b0);
		write_modulus(17'd2);
		send_element(16'h0000, 1'b0);
		send_element(16'h0001, 1'b0);
		write_modulus(17'd3);
		send_element(16'h0001, 1'b0);
		write_modulus(17'h1FFFF);
		send_element(16'hFFFF, 1'b0);
		send_element(16'h0000, 1'b0);
		run_phase(17'h1100B, 40);	// x^16+x^12+x^3+x+1
		run_phase(17'h1FFFF, 30);
		run_phase(17'd7, 80);	// x^2+x+1
		run_phase(17'd5, 60);	// x^2+1, reducible
		run_phase(17'h11B, 120);	// x^8+x^4+x^3+x+1
		run_phase(17'h0F, 60);	// reducible cubic
		run_phase(17'd19, 80);
		run_phase(17'($urandom_range(3, 17'h1FFFF)), 60);
		run_phase(17'($urandom_range(3, 255)), 100);
		run_phase(17'h25, 60);	// x^5+x^2+1
		@(posedge clk);
		wait (pending == 0);
		repeat (800) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/gmp_pkg.sv
design/gmp_mul.sv
design/gmp_dp.sv
design/gmp_ctrl.sv
design/gf2m_minimal_polynomial_unit.sv
sim/gf2m_minimal_polynomial_checker.sv
sim/gf2m_minimal_polynomial_unit_test.sv
